/* design/pwci_pkg.sv */
package pwci_pkg;

    // Field widths
    localparam int EVENT_W  = 16;
    localparam int PIXEL_W  = 12;
    localparam int SLICE_W  = 6;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 22;
    localparam int COUNT_W  = 7;
    localparam int BEFORE_W = 6;

    // Stream and configuration widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SLICES_IN_USE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLICES_BEFORE_PEAK = 2'd2;

    // Command codes carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register reset values
    localparam logic [COUNT_W-1:0]  SLICES_IN_USE_RST      = 7'd32;
    localparam logic [COUNT_W-1:0]  WINDOW_LENGTH_RST      = 7'd2;
    localparam logic [BEFORE_W-1:0] SLICES_BEFORE_PEAK_RST = 6'd1;

    // Read sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_TAIL  = 4'b0100,
        ST_DONE  = 4'b1000
    } rd_state_t;

    // Event-wide peak as seen by the read side
    typedef struct packed {
        logic [EVENT_W-1:0]  event_id;
        logic [PIXEL_W-1:0]  pixel;
        logic [SLICE_W-1:0]  slice;
    } peak_t;

endpackage

/* design/pwci_peak.sv */
module pwci_peak (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_en,
    input  logic                              in_range,
    input  logic                              last_sample,
    input  logic [pwci_pkg::EVENT_W-1:0]      event_id,
    input  logic [pwci_pkg::PIXEL_W-1:0]      pixel_index,
    input  logic [pwci_pkg::SLICE_W-1:0]      slice_index,
    input  logic signed [pwci_pkg::SAMPLE_W-1:0] sample_value,
    output pwci_pkg::peak_t                   peak
);
    import pwci_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg, value_next;
    logic [SLICE_W-1:0]         slice_reg, slice_next;
    logic [PIXEL_W-1:0]         pixel_reg, pixel_next;
    logic                       found_reg, found_next;
    logic                       new_event_reg, new_event_next;
    logic [EVENT_W-1:0]         event_reg, event_next;

    logic signed [SAMPLE_W-1:0] cur_value;
    logic [SLICE_W-1:0]         cur_slice;
    logic [PIXEL_W-1:0]         cur_pixel;
    logic                       cur_found;
    logic                       earlier;
    logic                       replace;

    // Start from a cleared peak on the first load of an event
    always_comb
    begin
        if (new_event_reg)
        begin
            cur_value = '0;
            cur_slice = '0;
            cur_pixel = '0;
            cur_found = 1'b0;
        end
        else
        begin
            cur_value = value_reg;
            cur_slice = slice_reg;
            cur_pixel = pixel_reg;
            cur_found = found_reg;
        end
        earlier = (pixel_index < cur_pixel) ||
                  ((pixel_index == cur_pixel) && (slice_index < cur_slice));
        replace = in_range &&
                  ((sample_value > cur_value) ||
                   (cur_found && (sample_value == cur_value) && earlier));
    end

    // Update peak and event bookkeeping on each load
    always_comb
    begin
        value_next     = value_reg;
        slice_next     = slice_reg;
        pixel_next     = pixel_reg;
        found_next     = found_reg;
        new_event_next = new_event_reg;
        event_next     = event_reg;
        if (load_en)
        begin
            value_next = cur_value;
            slice_next = cur_slice;
            pixel_next = cur_pixel;
            found_next = cur_found;
            if (new_event_reg)
            begin
                event_next = event_id;
            end
            if (replace)
            begin
                value_next = sample_value;
                slice_next = slice_index;
                pixel_next = pixel_index;
                found_next = 1'b1;
            end
            new_event_next = last_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg     <= '0;
            slice_reg     <= '0;
            pixel_reg     <= '0;
            found_reg     <= 1'b0;
            new_event_reg <= 1'b1;
            event_reg     <= '0;
        end
        else
        begin
            value_reg     <= value_next;
            slice_reg     <= slice_next;
            pixel_reg     <= pixel_next;
            found_reg     <= found_next;
            new_event_reg <= new_event_next;
            event_reg     <= event_next;
        end
    end

    assign peak.event_id = event_reg;
    assign peak.pixel    = pixel_reg;
    assign peak.slice    = slice_reg;

endmodule

/* design/peak_window_charge_integrator.sv */
// Channel   Direction  Transaction
// s_axis    in         one load (tuser=0) or one read (tuser=1) command
// m_axis    out        one window integral per read command
// cfg       in         one register write (index, data)
//
// Loads stream back to back.
// A read walks a window of W samples, W being window_length limited to
// 1 .. slices in use, through the single read port of the sample memory
// (ST_ISSUE), waits out the registered read (ST_TAIL), posts the result
// (ST_DONE) and returns to idle to take the next transaction.
// A result still waiting on m_axis holds the next read in its posting cycle,
// and the input with it. Reset clears control state, not the sample memory.
module peak_window_charge_integrator #(
    parameter int MAX_SLICES = 32,
    parameter int PIXELS     = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // event_id[15:0], pixel_index[27:16], slice_index[33:28],
    // sample_value[49:34], zero fill[55:50]
    input  logic [pwci_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tuser,   // command
    input  logic                                s_axis_tlast,   // last_sample
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // result_event[15:0], result_pixel[27:16], integral[49:28],
    // peak_slice[55:50]
    output logic [pwci_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwci_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwci_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pwci_pkg::*;

    localparam int DEPTH  = PIXELS * MAX_SLICES;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = PIXEL_W + COUNT_W;
    localparam logic [COUNT_W-1:0] MAX_S   = COUNT_W'(MAX_SLICES);
    localparam logic [PIXEL_W:0]   PIX_LIM = (PIXEL_W+1)'(PIXELS);

    // Input field split
    logic                       command;
    logic [EVENT_W-1:0]         event_id;
    logic [PIXEL_W-1:0]         pixel_index;
    logic [SLICE_W-1:0]         slice_index;
    logic signed [SAMPLE_W-1:0] sample_value;

    assign command      = s_axis_tuser;
    assign event_id     = s_axis_tdata[15:0];
    assign pixel_index  = s_axis_tdata[27:16];
    assign slice_index  = s_axis_tdata[33:28];
    assign sample_value = $signed(s_axis_tdata[49:34]);

    // Configuration registers
    logic [COUNT_W-1:0]  slices_reg;
    logic [COUNT_W-1:0]  window_reg;
    logic [BEFORE_W-1:0] before_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slices_reg <= SLICES_IN_USE_RST;
            window_reg <= WINDOW_LENGTH_RST;
            before_reg <= SLICES_BEFORE_PEAK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SLICES_IN_USE:      slices_reg <= cfg_data;
                REG_WINDOW_LENGTH:      window_reg <= cfg_data;
                REG_SLICES_BEFORE_PEAK: before_reg <= cfg_data[BEFORE_W-1:0];
                default:                ;
            endcase
        end
    end

    // Effective slices in use, window length and window start
    logic [COUNT_W-1:0] s_eff;
    logic [COUNT_W-1:0] wl_eff;
    logic [COUNT_W-1:0] win_lim;
    logic [COUNT_W-1:0] win_begin;

    peak_t peak;

    always_comb
    begin
        s_eff = slices_reg;
        if (s_eff == '0)
        begin
            s_eff = COUNT_W'(1);
        end
        if (s_eff > MAX_S)
        begin
            s_eff = MAX_S;
        end
        wl_eff = window_reg;
        if (wl_eff == '0)
        begin
            wl_eff = COUNT_W'(1);
        end
        if (wl_eff > s_eff)
        begin
            wl_eff = s_eff;
        end
        win_lim = s_eff - wl_eff;
        if (peak.slice > before_reg)
        begin
            win_begin = COUNT_W'(peak.slice - before_reg);
        end
        else
        begin
            win_begin = '0;
        end
        if (win_begin > win_lim)
        begin
            win_begin = win_lim;
        end
    end

    // Accepted transactions
    logic in_fire;
    logic load_en;
    logic read_fire;
    logic pix_ok;
    logic load_in_range;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_en       = in_fire && (command == CMD_LOAD);
    assign read_fire     = in_fire && (command == CMD_READ);
    assign pix_ok        = {1'b0, pixel_index} < PIX_LIM;
    assign load_in_range = pix_ok && ({1'b0, slice_index} < s_eff);

    pwci_peak u_peak (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_en      (load_en),
        .in_range     (load_in_range),
        .last_sample  (s_axis_tlast),
        .event_id     (event_id),
        .pixel_index  (pixel_index),
        .slice_index  (slice_index),
        .sample_value (sample_value),
        .peak         (peak)
    );

    // Addresses: pixel-major, MAX_SLICES entries per pixel
    logic [PROD_W-1:0] row_base;
    logic [PROD_W-1:0] wr_full;
    logic [PROD_W-1:0] rd_full;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_start;

    assign row_base = {{COUNT_W{1'b0}}, pixel_index} * PROD_W'(MAX_SLICES);
    assign wr_full  = row_base + PROD_W'(slice_index);
    assign rd_full  = row_base + PROD_W'(win_begin);
    assign wr_addr  = wr_full[AW-1:0];
    assign rd_start = pix_ok ? rd_full[AW-1:0] : '0;

    // Read sequencer
    rd_state_t            state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic                 pix_ok_reg, pix_ok_next;
    logic [PIXEL_W-1:0]   pix_reg, pix_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 mem_re;
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pix_ok_next    = pix_ok_reg;
        pix_next       = pix_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_re         = 1'b0;

        // Retire the posted result
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Fold in the sample read last cycle
        if (pend_reg && pix_ok_reg)
        begin
            acc_next = acc_reg + SUM_W'(rdata_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (read_fire)
                begin
                    addr_next   = rd_start;
                    cnt_next    = wl_eff;
                    pix_ok_next = pix_ok;
                    pix_next    = pixel_index;
                    acc_next    = '0;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                mem_re    = 1'b1;
                pend_next = 1'b1;
                addr_next = addr_reg + AW'(1);
                cnt_next  = cnt_reg - COUNT_W'(1);
                if (cnt_reg == COUNT_W'(1))
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {peak.slice, acc_reg, pix_reg, peak.event_id};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        cnt_reg      <= cnt_next;
        pix_ok_reg   <= pix_ok_next;
        pix_reg      <= pix_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // Sample memory: write on in-range load, registered read while walking the window
    logic signed [SAMPLE_W-1:0] sample_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (load_en && load_in_range)
        begin
            sample_mem[wr_addr] <= sample_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= sample_mem[addr_reg];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* design/pwci_checker.sv */
module pwci_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tuser,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [pwci_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready
);
    import pwci_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // A read transaction blocks the input while the window is walked
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_READ) |=> !s_axis_tready)
        else $error("input accepted during a read");

    // A load transaction never blocks the next one
    a_load_streams: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD) |=> s_axis_tready)
        else $error("load stalled the input");

    // A new result appears only at the end of a read
    a_result_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a read in progress");

endmodule

bind peak_window_charge_integrator pwci_checker u_pwci_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
